// ===== src/ialu_pkg.sv =====
package ialu_pkg;

    localparam int DATA_WIDTH_DEF = 64;
    localparam int OP_W    = 5;
    localparam int FULL_W  = 64;
    localparam int TW_W    = 7;
    localparam int ST_W    = 2;
    localparam int FIFO_DEPTH = 4;

    typedef enum logic [OP_W-1:0] {
        OP_MUL  = 5'd0,  OP_SDIV = 5'd1,  OP_UDIV = 5'd2,  OP_SREM = 5'd3,
        OP_UREM = 5'd4,  OP_ADD  = 5'd5,  OP_SUB  = 5'd6,  OP_SHL  = 5'd7,
        OP_LSHR = 5'd8,  OP_ASHR = 5'd9,  OP_AND  = 5'd10, OP_XOR  = 5'd11,
        OP_OR   = 5'd12, OP_ULT  = 5'd13, OP_UGT  = 5'd14, OP_ULE  = 5'd15,
        OP_UGE  = 5'd16, OP_SLT  = 5'd17, OP_SGT  = 5'd18, OP_SLE  = 5'd19,
        OP_SGE  = 5'd20, OP_EQ   = 5'd21, OP_NE   = 5'd22, OP_TRUNC = 5'd23
    } t_op;

    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_DIV0  = 2'd1;
    localparam logic [ST_W-1:0] ST_SHIFT = 2'd2;
    localparam logic [ST_W-1:0] ST_OVF   = 2'd3;

    // operation class decided at the front
    typedef struct packed {
        logic is_mul;
        logic is_div;
        logic div_rem;
        logic div_sgn;
        logic neg_q;
        logic neg_r;
        logic [ST_W-1:0] status;
    } t_cls;

endpackage

// ===== src/ialu_front.sv =====
module ialu_front
    import ialu_pkg::*;
#(
    parameter int DW = DATA_WIDTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [OP_W-1:0]   i_op,
    input  logic [FULL_W-1:0] i_a,
    input  logic [FULL_W-1:0] i_b,
    input  logic [TW_W-1:0]   i_tw,
    output logic              o_valid,
    input  logic              i_ready,
    output t_cls              o_cls,
    output logic [DW-1:0]     o_x,
    output logic [DW-1:0]     o_y,
    output logic [DW-1:0]     o_res
);
    localparam int AW = $clog2(FIFO_DEPTH);
    localparam int SW = $clog2(DW);

    logic [DW-1:0] a, b, ua, ub, mn, r;
    logic aneg, bneg, big, is_d, sgn, rem;
    logic [ST_W-1:0] st;
    logic [SW-1:0] sh;
    t_cls cls;

    assign a = i_a[DW-1:0];
    assign b = i_b[DW-1:0];
    assign aneg = a[DW-1];
    assign bneg = b[DW-1];
    assign ua = aneg ? (~a + 1'b1) : a;
    assign ub = bneg ? (~b + 1'b1) : b;
    assign mn = {1'b1, {(DW-1){1'b0}}};
    assign big = (b >= DW'(DW));
    assign sh = b[SW-1:0];

    always_comb begin
        r = '0;
        st = ST_OK;
        is_d = 1'b0;
        sgn = 1'b0;
        rem = 1'b0;
        case (t_op'(i_op))
            OP_MUL: r = '0;
            OP_SDIV, OP_SREM: begin
                rem = (i_op == OP_SREM);
                if (b == '0) begin
                    st = ST_DIV0;
                end else if (a == mn && b == '1) begin
                    st = ST_OVF;
                    r = rem ? '0 : mn;
                end else begin
                    is_d = 1'b1;
                    sgn = 1'b1;
                end
            end
            OP_UDIV, OP_UREM: begin
                rem = (i_op == OP_UREM);
                if (b == '0) st = ST_DIV0;
                else is_d = 1'b1;
            end
            OP_ADD: r = a + b;
            OP_SUB: r = a - b;
            OP_SHL:  if (big) st = ST_SHIFT; else r = a << sh;
            OP_LSHR: if (big) st = ST_SHIFT; else r = a >> sh;
            OP_ASHR: begin
                if (big) begin
                    st = ST_SHIFT;
                    r = {DW{aneg}};
                end else begin
                    r = DW'($signed(a) >>> sh);
                end
            end
            OP_AND: r = a & b;
            OP_XOR: r = a ^ b;
            OP_OR:  r = a | b;
            OP_ULT: r = DW'(a < b);
            OP_UGT: r = DW'(a > b);
            OP_ULE: r = DW'(a <= b);
            OP_UGE: r = DW'(a >= b);
            OP_SLT: r = DW'($signed(a) < $signed(b));
            OP_SGT: r = DW'($signed(a) > $signed(b));
            OP_SLE: r = DW'($signed(a) <= $signed(b));
            OP_SGE: r = DW'($signed(a) >= $signed(b));
            OP_EQ:  r = DW'(a == b);
            OP_NE:  r = DW'(a != b);
            OP_TRUNC: begin
                if (i_tw >= TW_W'(DW)) r = a;
                else r = a & ~({DW{1'b1}} << i_tw[SW-1:0]);
            end
            default: r = '0;
        endcase
        cls.is_mul = (i_op == OP_MUL);
        cls.is_div = is_d;
        cls.div_rem = rem;
        cls.div_sgn = sgn;
        cls.neg_q = sgn && (aneg != bneg);
        cls.neg_r = sgn && aneg;
        cls.status = st;
    end

    // short queue between front and back
    t_cls          r_q_cls [FIFO_DEPTH];
    logic [DW-1:0] r_q_x   [FIFO_DEPTH];
    logic [DW-1:0] r_q_y   [FIFO_DEPTH];
    logic [DW-1:0] r_q_r   [FIFO_DEPTH];
    logic [AW-1:0] r_wp, r_rp;
    logic [AW:0]   r_cnt;
    logic push, pop;

    assign o_ready = (r_cnt != (AW+1)'(FIFO_DEPTH));
    assign push = i_valid && o_ready;
    assign o_valid = (r_cnt != '0);
    assign pop = o_valid && i_ready;
    assign o_cls = r_q_cls[r_rp];
    assign o_x = r_q_x[r_rp];
    assign o_y = r_q_y[r_rp];
    assign o_res = r_q_r[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q_cls[r_wp] <= cls;
            r_q_x[r_wp] <= sgn ? ua : a;
            r_q_y[r_wp] <= sgn ? ub : b;
            r_q_r[r_wp] <= r;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_cnt <= '0;
        end else begin
            if (push) r_wp <= r_wp + 1'b1;
            if (pop) r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (AW+1)'(push) - (AW+1)'(pop);
        end
    end
endmodule

// ===== src/ialu_back.sv =====
module ialu_back
    import ialu_pkg::*;
#(
    parameter int DW = DATA_WIDTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  t_cls              i_cls,
    input  logic [DW-1:0]     i_x,
    input  logic [DW-1:0]     i_y,
    input  logic [DW-1:0]     i_res,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [DW-1:0]     o_res,
    output logic [ST_W-1:0]   o_st
);
    // restoring divider, one quotient bit per stage, stall by global enable
    // multiply split into half-width products over stages one and two
    localparam int NS = DW + 1;
    localparam int HW = DW / 2;
    localparam int LW = DW - HW;

    logic          r_v   [NS];
    t_cls          r_c   [NS];
    logic [DW-1:0] r_rem [NS];
    logic [DW-1:0] r_q   [NS];
    logic [DW-1:0] r_d   [NS];
    logic [DW-1:0] r_o   [NS];
    logic en;
    logic [DW-1:0] pp_lo, mul_sum;
    logic [HW-1:0] pp_xa, pp_xb;
    logic [DW-1:0] r_pp0;
    logic [HW-1:0] r_pp1;

    assign en = !r_v[NS-1] || i_ready;
    assign o_ready = en;
    assign o_valid = r_v[NS-1];

    assign pp_lo = r_q[0][LW-1:0] * r_d[0][LW-1:0];
    assign pp_xa = r_q[0][HW-1:0] * r_d[0][DW-1:LW];
    assign pp_xb = r_q[0][DW-1:LW] * r_d[0][HW-1:0];
    assign mul_sum = r_pp0 + {r_pp1, {LW{1'b0}}};

    always_comb begin
        logic [DW-1:0] q, rm;
        q = r_q[NS-1];
        rm = r_rem[NS-1];
        o_st = r_c[NS-1].status;
        if (!r_c[NS-1].is_div) o_res = r_o[NS-1];
        else if (r_c[NS-1].div_rem) o_res = r_c[NS-1].neg_r ? (~rm + 1'b1) : rm;
        else o_res = r_c[NS-1].neg_q ? (~q + 1'b1) : q;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NS; k++) r_v[k] <= 1'b0;
        end else if (en) begin
            r_v[0] <= i_valid;
            for (int k = 1; k < NS; k++) r_v[k] <= r_v[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c[0] <= i_cls;
            r_rem[0] <= '0;
            r_q[0] <= i_x;
            r_d[0] <= i_y;
            r_o[0] <= i_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_pp0 <= pp_lo;
            r_pp1 <= pp_xa + pp_xb;
        end
    end

    for (genvar s = 1; s < NS; s++) begin : g_st
        logic [DW:0] t, df;
        logic [DW-1:0] n_o;
        assign t = {r_rem[s-1], r_q[s-1][DW-1]};
        assign df = t - {1'b0, r_d[s-1]};
        assign n_o = (s == 2 && r_c[s-1].is_mul) ? mul_sum : r_o[s-1];
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_c[s] <= r_c[s-1];
                r_d[s] <= r_d[s-1];
                r_o[s] <= n_o;
                if (!df[DW]) begin
                    r_rem[s] <= df[DW-1:0];
                    r_q[s] <= {r_q[s-1][DW-2:0], 1'b1};
                end else begin
                    r_rem[s] <= t[DW-1:0];
                    r_q[s] <= {r_q[s-1][DW-2:0], 1'b0};
                end
            end
        end
    end
endmodule

// ===== src/integer_alu_with_compare_core.sv =====
// path: a result word passes through the queue and then the back pipeline registers,
// stage 0 through stage DATA_WIDTH; a low m_axis_tready holds the back pipeline
// (all operations take the same path, so results stay in order)
// throughput: one word per cycle while m_axis_tready does not stall the output; the divide runs
// one quotient bit per stage and the multiply is split into half-width products over two stages
// reset: synchronous active-low i_rst_n empties the queue and the pipeline
module integer_alu_with_compare_core
    import ialu_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // operand_a[63:0], operand_b[127:64], to_width[134:128], zero pad
    input  logic [135:0] s_axis_tdata,
    // req_type[4:0]
    input  logic [4:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // result_value[63:0], status[65:64], zero pad
    output logic [71:0]  m_axis_tdata
);
    logic f_valid, f_ready;
    t_cls f_cls;
    logic [DATA_WIDTH-1:0] f_x, f_y, f_r, b_res;
    logic [ST_W-1:0] b_st;

    ialu_front #(.DW(DATA_WIDTH)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready),
        .i_op(s_axis_tuser), .i_a(s_axis_tdata[63:0]), .i_b(s_axis_tdata[127:64]),
        .i_tw(s_axis_tdata[134:128]),
        .o_valid(f_valid), .i_ready(f_ready),
        .o_cls(f_cls), .o_x(f_x), .o_y(f_y), .o_res(f_r)
    );

    ialu_back #(.DW(DATA_WIDTH)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(f_valid), .o_ready(f_ready),
        .i_cls(f_cls), .i_x(f_x), .i_y(f_y), .i_res(f_r),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready),
        .o_res(b_res), .o_st(b_st)
    );

    assign m_axis_tdata = {6'd0, b_st, FULL_W'(b_res)};
endmodule

// ===== src/ialu_checker.sv =====
module ialu_checker
    import ialu_pkg::*;
(
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [71:0]  m_axis_tdata
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output word dropped or changed under stall");

    a_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[71:66] == 6'd0)
        else $error("pad bits set");

    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("valid after reset");

    a_cmp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[65:64] == ST_SHIFT |-> m_axis_tdata[63:1] == '0
            || m_axis_tdata[63:0] == '1)
        else $error("bad shift fill");
endmodule

bind integer_alu_with_compare_core ialu_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
);

// ===== tb/tb_integer_alu_with_compare_checker.sv =====
module tb_integer_alu_with_compare_checker
    import ialu_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    input  logic         i_s_tready,
    input  logic [135:0] i_s_tdata,
    input  logic [4:0]   i_s_tuser,
    input  logic         i_m_tvalid,
    input  logic         i_m_tready,
    input  logic [71:0]  i_m_tdata,
    output int           o_fail_count,
    output int           o_pending
);

    typedef struct packed {
        logic [ST_W-1:0]   status;
        logic [FULL_W-1:0] value;
    } t_res;

    t_res alu_results_due[$];

    function automatic t_res alu_compute(input logic [4:0] op, input logic [63:0] a,
                                         input logic [63:0] b, input logic [6:0] w);
        t_res r;
        logic [63:0] mn;
        logic [63:0] ua;
        logic [63:0] ub;
        r.value  = '0;
        r.status = ST_OK;
        mn = 64'h8000_0000_0000_0000;
        ua = a[63] ? -a : a;
        ub = b[63] ? -b : b;
        case (op)
            OP_MUL:  r.value = a * b;
            OP_SDIV, OP_SREM: begin
                if (b == 0) begin
                    r.status = ST_DIV0;
                end else if (a == mn && b == '1) begin
                    r.status = ST_OVF;
                    r.value  = (op == OP_SDIV) ? mn : 64'd0;
                end else if (op == OP_SDIV) begin
                    r.value = ua / ub;
                    if (a[63] != b[63]) r.value = -r.value;
                end else begin
                    r.value = ua % ub;
                    if (a[63]) r.value = -r.value;
                end
            end
            OP_UDIV: if (b == 0) r.status = ST_DIV0; else r.value = a / b;
            OP_UREM: if (b == 0) r.status = ST_DIV0; else r.value = a % b;
            OP_ADD:  r.value = a + b;
            OP_SUB:  r.value = a - b;
            OP_SHL:  if (b >= 64) r.status = ST_SHIFT; else r.value = a << b[5:0];
            OP_LSHR: if (b >= 64) r.status = ST_SHIFT; else r.value = a >> b[5:0];
            OP_ASHR: begin
                if (b >= 64) begin
                    r.status = ST_SHIFT;
                    r.value  = a[63] ? '1 : '0;
                end else begin
                    r.value = $signed(a) >>> b[5:0];
                end
            end
            OP_AND:  r.value = a & b;
            OP_XOR:  r.value = a ^ b;
            OP_OR:   r.value = a | b;
            OP_ULT:  r.value = 64'(a < b);
            OP_UGT:  r.value = 64'(a > b);
            OP_ULE:  r.value = 64'(a <= b);
            OP_UGE:  r.value = 64'(a >= b);
            OP_SLT:  r.value = 64'($signed(a) < $signed(b));
            OP_SGT:  r.value = 64'($signed(a) > $signed(b));
            OP_SLE:  r.value = 64'($signed(a) <= $signed(b));
            OP_SGE:  r.value = 64'($signed(a) >= $signed(b));
            OP_EQ:   r.value = 64'(a == b);
            OP_NE:   r.value = 64'(a != b);
            OP_TRUNC: r.value = (w < 64) ? (a & ((64'd1 << w[5:0]) - 64'd1)) : a;
            default: r.value = '0;
        endcase
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_res due;
        t_res got;
        if (!i_rst_n) begin
            o_fail_count <= 0;
            alu_results_due.delete();
        end else begin
            if (i_s_tvalid && i_s_tready)
                alu_results_due.push_back(alu_compute(i_s_tuser, i_s_tdata[63:0],
                                                      i_s_tdata[127:64], i_s_tdata[134:128]));
            if (i_m_tvalid && i_m_tready) begin
                got.value  = i_m_tdata[63:0];
                got.status = i_m_tdata[65:64];
                if (alu_results_due.size() == 0) begin
                    $display("%0t: expected no word actual %h", $time, got);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    due = alu_results_due.pop_front();
                    if (due.value !== got.value) begin
                        $display("%0t: value expected %h actual %h", $time, due.value,
                                 got.value);
                        o_fail_count <= o_fail_count + 1;
                    end else if (due.status !== got.status) begin
                        $display("%0t: status expected %0d actual %0d", $time, due.status,
                                 got.status);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
        o_pending <= alu_results_due.size();
    end

endmodule

// ===== tb/tb_integer_alu_with_compare_core.sv =====
module tb_integer_alu_with_compare_core;
    import ialu_pkg::*;

    localparam int N_RANDOM = 1250;
    localparam longint CYCLE_LIMIT = 200000;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [135:0] s_tdata = '0;
    logic [4:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b1;
    logic [71:0]  m_tdata;
    int           fail_count;
    int           pending;
    int           stall_left = 0;
    longint       cycle_count = 0;
    bit           stimulus_done = 1'b0;

    always #5 i_clk = ~i_clk;

    integer_alu_with_compare_core DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_tvalid), .s_axis_tready(s_tready),
        .s_axis_tdata(s_tdata), .s_axis_tuser(s_tuser),
        .m_axis_tvalid(m_tvalid), .m_axis_tready(m_tready), .m_axis_tdata(m_tdata)
    );

    tb_integer_alu_with_compare_checker checker_i (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(s_tvalid), .i_s_tready(s_tready), .i_s_tdata(s_tdata),
        .i_s_tuser(s_tuser), .i_m_tvalid(m_tvalid), .i_m_tready(m_tready),
        .i_m_tdata(m_tdata), .o_fail_count(fail_count), .o_pending(pending)
    );

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // result side: random stall per word, sometimes none at all
    always @(posedge i_clk) begin
        int stall;
        if (i_rst_n) begin
            if (m_tready && m_tvalid) begin
                stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
                if (stall != 0) begin
                    m_tready <= 1'b0;
                    stall_left <= stall;
                end
            end else if (!m_tready) begin
                if (stall_left <= 1) m_tready <= 1'b1;
                stall_left <= stall_left - 1;
            end
        end
    end

    function automatic logic [63:0] pick_operand();
        case ($urandom_range(0, 7))
            0: return 64'h8000_0000_0000_0000;
            1: return '1;
            2: return 64'($urandom_range(0, 70));
            3: return -64'($urandom_range(1, 70));
            4: return 64'h7fff_ffff_ffff_ffff;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic send_word(input logic [4:0] op, input logic [63:0] a,
                             input logic [63:0] b, input logic [6:0] w);
        int gap;
        gap = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 11) : 0;
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {1'b0, w, b, a};
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
    endtask

    initial begin
        logic [63:0] mn;
        mn = 64'h8000_0000_0000_0000;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        for (int op = 0; op < 24; op++)
            send_word(5'(op), {$urandom, $urandom}, 64'($urandom_range(0, 63)), 7'd13);
        send_word(OP_SDIV, mn, '1, 7'd0);
        send_word(OP_SREM, mn, '1, 7'd0);
        send_word(OP_UDIV, '1, '0, 7'd0);
        send_word(OP_SREM, 64'd5, '0, 7'd0);
        send_word(OP_ASHR, mn, 64'd64, 7'd0);
        send_word(OP_SHL, '1, '1, 7'd0);
        send_word(OP_TRUNC, '1, '0, 7'd0);
        send_word(OP_TRUNC, '1, '0, 7'd127);
        send_word(5'd31, '1, '1, 7'd64);
        for (int i = 0; i < N_RANDOM; i++)
            send_word(5'($urandom_range(0, ($urandom_range(0, 15) == 0) ? 31 : 23)),
                      pick_operand(), ($urandom_range(0, 3) == 0) ?
                      64'($urandom_range(0, 70)) : pick_operand(),
                      7'($urandom_range(0, 127)));
        s_tvalid <= 1'b0;
        stimulus_done = 1'b1;
    end

    initial begin
        wait (stimulus_done);
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
